// ===== rtl/core/ldvw_pkg.sv =====
package ldvw_pkg;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0]  ADDR_CMD_BASE = 8'h80;
  localparam logic [7:0]  ASCII_ZERO    = 8'h30;
  localparam logic [13:0] MAX_FOUR      = 14'd9999;
  localparam logic [13:0] MAX_TWO       = 14'd99;
  localparam logic [13:0] PLACE_1000    = 14'd1000;
  localparam logic [13:0] PLACE_100     = 14'd100;
  localparam logic [13:0] PLACE_10      = 14'd10;

  localparam logic [2:0] IDX_ADDR = 3'd0;
  localparam logic [2:0] IDX_LAST = 3'd4;
  localparam logic [2:0] TWO_SKIP = 3'd2;

  typedef struct packed {
    logic        command;
    logic [6:0]  position;
    logic [13:0] value;
  } in_word_t;

  typedef struct packed {
    logic       is_data;
    logic [7:0] bus_byte;
    logic       last;
  } out_word_t;

  // dig[0] thousands .. dig[3] units
  typedef struct packed {
    logic            four;
    logic [6:0]      position;
    logic [3:0][3:0] dig;
  } job_t;

  typedef struct packed {
    logic [3:0]  digit;
    logic [13:0] rest;
  } split_t;

  function automatic split_t split_digit(input logic [13:0] num, input logic [13:0] place);
    split_t      res;
    logic [17:0] lim;
    res.digit = '0;
    for (int k = 1; k < 10; k++) begin
      lim = 18'(k) * {4'b0, place};
      if ({4'b0, num} >= lim) begin
        res.digit = 4'(k);
      end
    end
    lim = {14'b0, res.digit} * {4'b0, place};
    res.rest = num - lim[13:0];
    return res;
  endfunction

endpackage

// ===== rtl/core/ldvw_front.sv =====
module ldvw_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ldvw_pkg::in_word_t in_word,
  output logic               push,
  output ldvw_pkg::job_t     push_job,
  input  logic               full
);

  logic           en;
  logic [13:0]    sat;
  ldvw_pkg::split_t sp_a, sp_b, sp_c;

  logic           a_v_r, b_v_r, c_v_r;
  logic           a_four_r, b_four_r;
  logic [6:0]     a_pos_r, b_pos_r;
  logic [13:0]    a_rem_r, b_rem_r;
  logic [3:0]     a_d0_r, b_d0_r, b_d1_r;
  ldvw_pkg::job_t c_job_r;

  assign en       = !(c_v_r && full);
  assign in_stall = !en;
  assign push     = c_v_r && !full;
  assign push_job = c_job_r;

  always_comb begin
    if (in_word.command) begin
      sat = (in_word.value > ldvw_pkg::MAX_FOUR) ? ldvw_pkg::MAX_FOUR : in_word.value;
    end else begin
      sat = (in_word.value > ldvw_pkg::MAX_TWO) ? ldvw_pkg::MAX_TWO : in_word.value;
    end
  end

  assign sp_a = ldvw_pkg::split_digit(sat, ldvw_pkg::PLACE_1000);
  assign sp_b = ldvw_pkg::split_digit(a_rem_r, ldvw_pkg::PLACE_100);
  assign sp_c = ldvw_pkg::split_digit(b_rem_r, ldvw_pkg::PLACE_10);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
    end else if (en) begin
      a_v_r <= in_valid;
      b_v_r <= a_v_r;
      c_v_r <= b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_four_r <= in_word.command;
      a_pos_r  <= in_word.position;
      a_rem_r  <= sp_a.rest;
      a_d0_r   <= sp_a.digit;

      b_four_r <= a_four_r;
      b_pos_r  <= a_pos_r;
      b_rem_r  <= sp_b.rest;
      b_d0_r   <= a_d0_r;
      b_d1_r   <= sp_b.digit;

      c_job_r.four     <= b_four_r;
      c_job_r.position <= b_pos_r;
      c_job_r.dig[0]   <= b_d0_r;
      c_job_r.dig[1]   <= b_d1_r;
      c_job_r.dig[2]   <= sp_c.digit;
      c_job_r.dig[3]   <= sp_c.rest[3:0];
    end
  end

endmodule

// ===== rtl/core/ldvw_queue.sv =====
module ldvw_queue #(
  parameter int DEPTH = ldvw_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  ldvw_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output ldvw_pkg::job_t head_job
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  ldvw_pkg::job_t mem [DEPTH];
  logic [PW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]  cnt_r;
  logic           do_push, do_pop;

  assign full       = (cnt_r == FULL_CNT);
  assign head_valid = (cnt_r != '0);
  assign head_job   = mem[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_job;
    end
  end

endmodule

// ===== rtl/core/ldvw_back.sv =====
module ldvw_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                head_valid,
  input  ldvw_pkg::job_t      head_job,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output ldvw_pkg::out_word_t out_word
);

  logic                adv;
  logic [2:0]          idx_r;
  logic [2:0]          eff;
  logic [1:0]          dsel;
  logic                is_last;
  logic                out_valid_r;
  ldvw_pkg::out_word_t out_word_r;
  ldvw_pkg::out_word_t word_nxt;

  assign adv     = !out_valid_r || !out_stall;
  assign eff     = head_job.four ? idx_r : idx_r + ldvw_pkg::TWO_SKIP;
  assign dsel    = 2'(eff - 3'd1);
  assign is_last = (idx_r != ldvw_pkg::IDX_ADDR) && (eff == ldvw_pkg::IDX_LAST);
  assign pop     = adv && head_valid && is_last;

  always_comb begin
    if (idx_r == ldvw_pkg::IDX_ADDR) begin
      word_nxt.is_data  = 1'b0;
      word_nxt.bus_byte = ldvw_pkg::ADDR_CMD_BASE | {1'b0, head_job.position};
      word_nxt.last     = 1'b0;
    end else begin
      word_nxt.is_data  = 1'b1;
      word_nxt.bus_byte = ldvw_pkg::ASCII_ZERO | {4'b0, head_job.dig[dsel]};
      word_nxt.last     = is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= ldvw_pkg::IDX_ADDR;
    end else if (adv) begin
      out_valid_r <= head_valid;
      if (head_valid) begin
        idx_r <= is_last ? ldvw_pkg::IDX_ADDR : idx_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && head_valid) begin
      out_word_r <= word_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

// ===== rtl/core/lcd_decimal_value_writer_unit.sv =====
// channel | ports                        | word
// in      | in_valid, in_stall, in_word   | command, position, value
// out     | out_valid, out_stall, out_word | is_data, bus_byte, last
//
// Front: three-stage digit split (thousands, hundreds, tens/units), one request per cycle unless stalled.
// Back: one bus byte per cycle while out_stall is low, 3 per two-digit request, 5 per four-digit request;
// the back end's byte sequencer sets the sustained rate.
// Path from accept to the address byte: 3 front stages, the queue write, then the output register.
// Synchronous active-low reset clears valids, pointers and the byte index.
// out_stall holds the output word; a full queue with a job in the last front stage stalls the whole front pipeline.
module lcd_decimal_value_writer_unit #(
  parameter int QUEUE_DEPTH = ldvw_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ldvw_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output ldvw_pkg::out_word_t out_word
);

  logic           push, full, pop, head_valid;
  ldvw_pkg::job_t push_job, head_job;

  ldvw_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .push     (push),
    .push_job (push_job),
    .full     (full)
  );

  ldvw_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (push_job),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  ldvw_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_word   (out_word)
  );

endmodule

// ===== dv/lcd_decimal_value_writer_unit_tb.sv =====
`timescale 1ns / 1ps

module lcd_decimal_value_writer_unit_tb;

  localparam int          QUIET_LIMIT = 2000;
  localparam int          LONG_HOLD   = 120;
  localparam int          TAIL_CYCLES = 12;
  localparam int          RAND_PER_PH = 150;
  localparam int          DIR_ROWS    = 20;
  localparam logic [31:0] NO_TEXT     = 32'd0;

  // text holds the expected digit characters, right-justified; NO_TEXT -> predictor
  typedef struct packed {
    logic        command;
    logic [6:0]  position;
    logic [13:0] value;
    logic [31:0] text;
  } lcd_row_t;

  lcd_row_t dir_rows [DIR_ROWS] = '{
    '{1'b0, 7'd0,   14'd0,     "00"},
    '{1'b0, 7'd127, 14'd99,    "99"},
    '{1'b0, 7'd1,   14'd100,   "99"},
    '{1'b0, 7'd126, 14'd16383, "99"},
    '{1'b0, 7'h2a,  14'd7,     NO_TEXT},
    '{1'b0, 7'h40,  14'd42,    NO_TEXT},
    '{1'b0, 7'h55,  14'd10,    NO_TEXT},
    '{1'b0, 7'h2b,  14'd8192,  "99"},
    '{1'b1, 7'd0,   14'd0,     "0000"},
    '{1'b1, 7'd127, 14'd9999,  "9999"},
    '{1'b1, 7'h14,  14'd10000, "9999"},
    '{1'b1, 7'h54,  14'd16383, "9999"},
    '{1'b1, 7'h67,  14'd1000,  "1000"},
    '{1'b1, 7'h40,  14'd9,     "0009"},
    '{1'b1, 7'h0f,  14'd1234,  NO_TEXT},
    '{1'b1, 7'h70,  14'd8191,  NO_TEXT},
    '{1'b1, 7'h33,  14'd5050,  NO_TEXT},
    '{1'b1, 7'h7e,  14'd9998,  NO_TEXT},
    '{1'b0, 7'h01,  14'd98,    NO_TEXT},
    '{1'b1, 7'h2a,  14'd10,    "0010"}
  };

  logic                clk;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  ldvw_pkg::in_word_t  in_word   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  ldvw_pkg::out_word_t out_word;

  ldvw_pkg::out_word_t lcd_bytes_q [$];
  logic [31:0] cur_text      = NO_TEXT;
  int          send_idle_pct = 0;
  int          stall_pct     = 0;
  int          mismatch_count = 0;
  int          quiet_cycles  = 0;
  int          hold_left     = 0;
  logic        hold_req      = 1'b0;
  logic        hold_taken    = 1'b0;

  lcd_decimal_value_writer_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // expected run: set-address byte, then the digits most significant first
  function automatic void queue_lcd_run(input ldvw_pkg::in_word_t w, input logic [31:0] text);
    int unsigned         v;
    int                  n;
    int                  dig [4];
    ldvw_pkg::out_word_t o;
    v = w.value;
    n = w.command ? 4 : 2;
    if (w.command) begin
      if (v > ldvw_pkg::MAX_FOUR) v = ldvw_pkg::MAX_FOUR;
      dig[0] = v / ldvw_pkg::PLACE_1000;
      dig[1] = (v % ldvw_pkg::PLACE_1000) / ldvw_pkg::PLACE_100;
      dig[2] = (v % ldvw_pkg::PLACE_100) / ldvw_pkg::PLACE_10;
      dig[3] = v % ldvw_pkg::PLACE_10;
    end else begin
      if (v > ldvw_pkg::MAX_TWO) v = ldvw_pkg::MAX_TWO;
      dig[0] = v / ldvw_pkg::PLACE_10;
      dig[1] = v % ldvw_pkg::PLACE_10;
    end
    o.is_data  = 1'b0;
    o.bus_byte = ldvw_pkg::ADDR_CMD_BASE + {1'b0, w.position};
    o.last     = 1'b0;
    lcd_bytes_q.push_back(o);
    for (int i = 0; i < n; i++) begin
      o.is_data  = 1'b1;
      o.bus_byte = (text != NO_TEXT) ? text[8*(n-1-i) +: 8]
                                     : ldvw_pkg::ASCII_ZERO + 8'(dig[i]);
      o.last     = (i == n - 1);
      lcd_bytes_q.push_back(o);
    end
  endfunction

  function automatic ldvw_pkg::in_word_t random_request();
    ldvw_pkg::in_word_t w;
    w.command  = 1'($urandom_range(1));
    w.position = 7'($urandom_range(127));
    case ($urandom_range(9))
      0, 1, 2: w.value = 14'($urandom_range(w.command ? 9999 : 99));
      3, 4, 5: w.value = 14'($urandom_range(9999));
      6, 7:    w.value = 14'($urandom_range(16383));
      8:       w.value = 14'($urandom_range(120, 90));
      default: w.value = 14'($urandom_range(10010, 9990));
    endcase
    return w;
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("%0t: %s mismatch: got 0x%0h, expected 0x%0h", $time, field, got, want);
    mismatch_count++;
  endtask

  task automatic send_request(input ldvw_pkg::in_word_t w, input logic [31:0] text);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    cur_text = text;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) queue_lcd_run(in_word, cur_text);
  end

  always @(posedge clk) begin
    ldvw_pkg::out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (lcd_bytes_q.size() == 0) begin
        report_mismatch("unexpected word", out_word, 0);
      end else begin
        want = lcd_bytes_q.pop_front();
        if (out_word.is_data !== want.is_data)
          report_mismatch("is_data", out_word.is_data, want.is_data);
        if (out_word.bus_byte !== want.bus_byte)
          report_mismatch("bus_byte", out_word.bus_byte, want.bus_byte);
        if (out_word.last !== want.last)
          report_mismatch("last", out_word.last, want.last);
      end
    end
  end

  // receiver stall; one long hold-off when requested
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_taken) begin
      out_stall  <= 1'b1;
      hold_taken <= 1'b1;
      hold_left  <= LONG_HOLD;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("lcd_decimal_value_writer_unit_tb NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    ldvw_pkg::in_word_t w;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 21;
    stall_pct     = 76;
    for (int r = 0; r < DIR_ROWS; r++) begin
      w.command  = dir_rows[r].command;
      w.position = dir_rows[r].position;
      w.value    = dir_rows[r].value;
      send_request(w, dir_rows[r].text);
    end
    for (int k = 0; k < RAND_PER_PH; k++) send_request(random_request(), NO_TEXT);

    send_idle_pct = 76;
    stall_pct     = 21;
    for (int k = 0; k < RAND_PER_PH; k++) send_request(random_request(), NO_TEXT);

    // no idling; long receiver hold-off fills the block and backs up the input
    send_idle_pct = 0;
    stall_pct     = 0;
    in_valid <= 1'b0;
    @(posedge clk);
    hold_req = 1'b1;
    @(negedge clk);
    for (int k = 0; k < RAND_PER_PH; k++) send_request(random_request(), NO_TEXT);
    in_valid <= 1'b0;

    while (lcd_bytes_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("lcd_decimal_value_writer_unit_tb OK");
    end else begin
      $display("lcd_decimal_value_writer_unit_tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/ldvw_pkg.sv
rtl/core/ldvw_front.sv
rtl/core/ldvw_queue.sv
rtl/core/ldvw_back.sv
rtl/core/lcd_decimal_value_writer_unit.sv
dv/lcd_decimal_value_writer_unit_tb.sv
